// ===== sv/olre_pkg.sv =====
// olre_pkg: shared constants, request and status codes, and the ram request
// struct for the ordered record list engine. no dependencies.
package olre_pkg;

   localparam int CAPACITY   = 64;
   localparam int NAME_BYTES = 8;

   localparam int TYPE_W  = 2;
   localparam int POS_W   = 8;
   localparam int NAME_W  = 64;
   localparam int AGE_W   = 8;
   localparam int STAT_W  = 2;
   localparam int FOUND_W = 7;
   localparam int OCNT_W  = 7;

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int DATA_W = NAME_W + AGE_W;

   localparam logic [NAME_W-1:0] NAME_MASK = {NAME_W{1'b1}} >> (NAME_W - 8 * NAME_BYTES);
   localparam logic [FOUND_W-1:0] NONE_IDX = {FOUND_W{1'b1}};

   localparam logic [TYPE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [TYPE_W-1:0] OP_DELETE = 2'd1;
   localparam logic [TYPE_W-1:0] OP_LOCATE = 2'd2;
   localparam logic [TYPE_W-1:0] OP_SORTED = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  waddr;
      logic [DATA_W-1:0] wdata;
      logic              re;
      logic [IDX_W-1:0]  raddr;
   } ram_req_type;

endpackage

// ===== sv/ordered_record_list_engine.sv =====
// ordered_record_list_engine: top level, bounded record list with positional
// and sorted insert, delete and locate. depends on olre_pkg, olre_ram, olre_seq.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   req_type, req_position,
//                                              req_name_key, req_age
//   rsp       out        rsp_valid/rsp_stall   rsp_status, rsp_found_index,
//                                              rsp_entry_count
//
// one transaction at a time; the record ram has a single read port and the
// walk touches one entry per cycle, so a transaction's length grows with the
// number of entries moved or searched.
// reset clears the entry count, the state and rsp_valid; the ram is not cleared.
// rsp is registered, so a new req is taken while a response waits on stall.
module ordered_record_list_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [olre_pkg::TYPE_W-1:0]         req_type,
   input  logic [olre_pkg::POS_W-1:0]          req_position,
   input  logic [olre_pkg::NAME_W-1:0]         req_name_key,
   input  logic [olre_pkg::AGE_W-1:0]          req_age,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [olre_pkg::STAT_W-1:0]         rsp_status,
   output logic signed [olre_pkg::FOUND_W-1:0] rsp_found_index,
   output logic [olre_pkg::OCNT_W-1:0]         rsp_entry_count
);
   import olre_pkg::*;

   ram_req_type       ram_req;
   logic [DATA_W-1:0] ram_rd_data;

   olre_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_position    (req_position),
      .req_name_key    (req_name_key),
      .req_age         (req_age),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_entry_count (rsp_entry_count),
      .ram_req         (ram_req),
      .ram_rd_data     (ram_rd_data)
   );

   olre_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_req.we),
      .wr_addr (ram_req.waddr),
      .wr_data (ram_req.wdata),
      .rd_en   (ram_req.re),
      .rd_addr (ram_req.raddr),
      .rd_data (ram_rd_data)
   );

endmodule

// ===== sv/olre_ram.sv =====
// olre_ram: generic simple dual-port ram, one write and one registered read
// port. no dependencies.
module olre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/olre_seq.sv =====
// olre_seq: request sequencer; walks the record ram one entry per cycle to
// shift, search or place records. depends on olre_pkg.
module olre_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [olre_pkg::TYPE_W-1:0]     req_type,
   input  logic [olre_pkg::POS_W-1:0]      req_position,
   input  logic [olre_pkg::NAME_W-1:0]     req_name_key,
   input  logic [olre_pkg::AGE_W-1:0]      req_age,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [olre_pkg::STAT_W-1:0]     rsp_status,
   output logic signed [olre_pkg::FOUND_W-1:0] rsp_found_index,
   output logic [olre_pkg::OCNT_W-1:0]     rsp_entry_count,
   output olre_pkg::ram_req_type           ram_req,
   input  logic [olre_pkg::DATA_W-1:0]     ram_rd_data
);
   import olre_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOOP = 2'd1;
   localparam logic [1:0] S_WKEY = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [TYPE_W-1:0]  op_ff, op_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [NAME_W-1:0]  key_ff, key_in;
   logic [AGE_W-1:0]   age_ff, age_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   pend_ff, pend_in;
   logic [IDX_W-1:0]   kpos_ff, kpos_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic [FOUND_W-1:0] found_ff, found_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [FOUND_W-1:0] rsp_found_ff, rsp_found_in;
   logic [OCNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [CMP_W-1:0]   req_pos_c, cnt_c, pos_c, pend_c;
   logic [CNT_W-1:0]   pend_next_cnt;
   logic [NAME_W-1:0]  rd_name;
   logic [AGE_W-1:0]   rd_age;
   logic [NAME_W-1:0]  req_key_m;
   logic               rsp_free;

   assign req_pos_c     = CMP_W'(req_position);
   assign cnt_c         = CMP_W'(count_ff);
   assign pos_c         = CMP_W'(pos_ff);
   assign pend_c        = CMP_W'(pend_ff);
   assign pend_next_cnt = CNT_W'(pend_ff) + CNT_W'(1);
   assign rd_name       = ram_rd_data[DATA_W-1:AGE_W];
   assign rd_age        = ram_rd_data[AGE_W-1:0];
   assign req_key_m     = req_name_key & NAME_MASK;
   assign rsp_free      = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      pos_in    = pos_ff;
      key_in    = key_ff;
      age_in    = age_ff;
      count_in  = count_ff;
      pend_in   = pend_ff;
      kpos_in   = kpos_ff;
      status_in = status_ff;
      found_in  = found_ff;
      ram_req   = '0;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_type;
               pos_in    = req_position;
               key_in    = req_key_m;
               age_in    = req_age;
               status_in = ST_OK;
               found_in  = NONE_IDX;
               state_in  = S_FIN;
               case (req_type)
                  OP_INSERT: begin
                     if (req_pos_c > cnt_c) begin
                        status_in = ST_BAD_POS;
                     end else if (count_ff >= CNT_W'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else if (req_pos_c == cnt_c) begin
                        kpos_in  = IDX_W'(req_position);
                        state_in = S_WKEY;
                     end else begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = IDX_W'(count_ff - CNT_W'(1));
                        pend_in       = IDX_W'(count_ff - CNT_W'(1));
                        state_in      = S_LOOP;
                     end
                  end
                  OP_DELETE: begin
                     if (req_pos_c >= cnt_c) begin
                        status_in = ST_BAD_POS;
                     end else if (req_pos_c + CMP_W'(1) == cnt_c) begin
                        count_in = count_ff - CNT_W'(1);
                     end else begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = IDX_W'(req_pos_c + CMP_W'(1));
                        pend_in       = IDX_W'(req_pos_c + CMP_W'(1));
                        state_in      = S_LOOP;
                     end
                  end
                  OP_LOCATE: begin
                     if (count_ff != '0) begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = '0;
                        pend_in       = '0;
                        state_in      = S_LOOP;
                     end
                  end
                  default: begin
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else if (count_ff == '0) begin
                        kpos_in  = '0;
                        state_in = S_WKEY;
                     end else begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = IDX_W'(count_ff - CNT_W'(1));
                        pend_in       = IDX_W'(count_ff - CNT_W'(1));
                        state_in      = S_LOOP;
                     end
                  end
               endcase
            end
         end
         // read and write addresses never coincide while walking, so the
         // ram needs no forwarding
         S_LOOP: begin
            case (op_ff)
               OP_DELETE: begin
                  ram_req.we    = 1'b1;
                  ram_req.waddr = pend_ff - IDX_W'(1);
                  ram_req.wdata = ram_rd_data;
                  if (pend_next_cnt == count_ff) begin
                     count_in = count_ff - CNT_W'(1);
                     state_in = S_FIN;
                  end else begin
                     ram_req.re    = 1'b1;
                     ram_req.raddr = pend_ff + IDX_W'(1);
                     pend_in       = pend_ff + IDX_W'(1);
                  end
               end
               OP_LOCATE: begin
                  if (rd_name == key_ff && rd_age == age_ff) begin
                     found_in = FOUND_W'(pend_ff);
                     state_in = S_FIN;
                  end else if (pend_next_cnt == count_ff) begin
                     state_in = S_FIN;
                  end else begin
                     ram_req.re    = 1'b1;
                     ram_req.raddr = pend_ff + IDX_W'(1);
                     pend_in       = pend_ff + IDX_W'(1);
                  end
               end
               default: begin
                  // insert and sorted insert walk down from the top entry
                  if (op_ff == OP_INSERT || rd_name > key_ff) begin
                     ram_req.we    = 1'b1;
                     ram_req.waddr = pend_ff + IDX_W'(1);
                     ram_req.wdata = ram_rd_data;
                     if (pend_ff == '0 || (op_ff == OP_INSERT && pend_c == pos_c)) begin
                        kpos_in  = pend_ff;
                        state_in = S_WKEY;
                     end else begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = pend_ff - IDX_W'(1);
                        pend_in       = pend_ff - IDX_W'(1);
                     end
                  end else begin
                     kpos_in  = pend_ff + IDX_W'(1);
                     state_in = S_WKEY;
                  end
               end
            endcase
         end
         S_WKEY: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = kpos_ff;
            ram_req.wdata = {key_ff, age_ff};
            count_in      = count_ff + CNT_W'(1);
            state_in      = S_FIN;
         end
         default: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_found_in  = found_ff;
               rsp_count_in  = OCNT_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      age_ff        <= age_in;
      pend_ff       <= pend_in;
      kpos_ff       <= kpos_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

// ===== test/ordered_record_list_engine_tb.sv =====
`timescale 1ns / 1ps
// ordered_record_list_engine_tb: self-checking bench for the record list engine,
// with a shadow list that predicts every response and random valid/stall idling.
// depends on olre_pkg and ordered_record_list_engine.
module ordered_record_list_engine_tb;
   import olre_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int RANDOM_COUNT = 1650;
   localparam int CALM_TAIL    = 200;

   typedef struct packed {
      logic [TYPE_W-1:0] kind;
      logic [POS_W-1:0]  position;
      logic [NAME_W-1:0] name_key;
      logic [AGE_W-1:0]  age;
   } record_request_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [FOUND_W-1:0] found_index;
      logic [OCNT_W-1:0]  entry_count;
   } record_reply_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [TYPE_W-1:0]          req_type = OP_LOCATE;
   logic [POS_W-1:0]           req_position = '0;
   logic [NAME_W-1:0]          req_name_key = '0;
   logic [AGE_W-1:0]           req_age = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [STAT_W-1:0]          rsp_status;
   logic signed [FOUND_W-1:0]  rsp_found_index;
   logic [OCNT_W-1:0]          rsp_entry_count;

   // shadow copy of the list contents
   logic [NAME_W-1:0] list_names [CAPACITY];
   logic [AGE_W-1:0]  list_ages [CAPACITY];
   int                list_count = 0;

   record_request_type pending_requests[$];
   record_reply_type   expected_replies[$];
   record_request_type in_flight;
   record_reply_type   next_reply;
   bit              idling_enabled = 1'b1;
   int              send_gap = 0;
   int              hold_left = 0;
   int              quiet_cycles = 0;
   int              failures = 0;

   ordered_record_list_engine dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_position    (req_position),
      .req_name_key    (req_name_key),
      .req_age         (req_age),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_entry_count (rsp_entry_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // applies one transaction to the shadow list and returns its response
   function automatic record_reply_type apply_record_request(record_request_type rq);
      record_reply_type  rp;
      logic [NAME_W-1:0] key;
      int                pos;
      int                i;
      key = rq.name_key & NAME_MASK;
      pos = int'(rq.position);
      rp.status = ST_OK;
      rp.found_index = NONE_IDX;
      case (rq.kind)
         OP_INSERT: begin
            if (pos > list_count) begin
               rp.status = ST_BAD_POS;
            end else if (list_count >= CAPACITY) begin
               rp.status = ST_FULL;
            end else begin
               for (i = list_count; i > pos; i--) begin
                  list_names[i] = list_names[i-1];
                  list_ages[i] = list_ages[i-1];
               end
               list_names[pos] = key;
               list_ages[pos] = rq.age;
               list_count++;
            end
         end
         OP_DELETE: begin
            if (pos >= list_count) begin
               rp.status = ST_BAD_POS;
            end else begin
               for (i = pos; i + 1 < list_count; i++) begin
                  list_names[i] = list_names[i+1];
                  list_ages[i] = list_ages[i+1];
               end
               list_count--;
            end
         end
         OP_LOCATE: begin
            for (i = list_count - 1; i >= 0; i--) begin
               if (list_names[i] == key && list_ages[i] == rq.age)
                  rp.found_index = i[FOUND_W-1:0];
            end
         end
         default: begin
            if (list_count >= CAPACITY) begin
               rp.status = ST_FULL;
            end else begin
               i = list_count;
               while (i > 0 && list_names[i-1] > key) begin
                  list_names[i] = list_names[i-1];
                  list_ages[i] = list_ages[i-1];
                  i--;
               end
               list_names[i] = key;
               list_ages[i] = rq.age;
               list_count++;
            end
         end
      endcase
      rp.entry_count = list_count[OCNT_W-1:0];
      return rp;
   endfunction

   function automatic record_request_type make_request(logic [TYPE_W-1:0] kind,
         logic [POS_W-1:0] position, logic [NAME_W-1:0] name_key, logic [AGE_W-1:0] age);
      record_request_type rq;
      rq.kind = kind;
      rq.position = position;
      rq.name_key = name_key;
      rq.age = age;
      return rq;
   endfunction

   // small pool and stored names make equal keys common
   function automatic logic [NAME_W-1:0] pick_name();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         return '0;
      if (pick == 1)
         return '1;
      if (pick <= 4) begin
         case ($urandom_range(0, 5))
            0: return 64'h4150_5000_0000_0000;
            1: return 64'h4150_5045_0000_0000;
            2: return 64'h4d49_4400_0000_0000;
            3: return 64'h5a55_4c55_0000_0000;
            4: return 64'h8000_0000_0000_0001;
            default: return 64'h0000_0000_0000_0041;
         endcase
      end
      if (pick <= 6 && list_count > 0)
         return list_names[$urandom_range(0, list_count - 1)];
      return {$urandom, $urandom};
   endfunction

   function automatic logic [AGE_W-1:0] pick_age();
      if ($urandom_range(0, 3) == 0)
         return AGE_W'($urandom_range(0, 3));
      return AGE_W'($urandom_range(0, 255));
   endfunction

   function automatic record_request_type make_random_request(bit growing);
      record_request_type rq;
      int              roll;
      int              idx;
      roll = $urandom_range(0, 99);
      rq.name_key = pick_name();
      rq.age = pick_age();
      rq.position = '0;
      if (growing)
         rq.kind = (roll < 40) ? OP_SORTED : (roll < 70) ? OP_INSERT :
                   (roll < 82) ? OP_LOCATE : OP_DELETE;
      else
         rq.kind = (roll < 45) ? OP_DELETE : (roll < 65) ? OP_LOCATE :
                   (roll < 75) ? OP_INSERT : OP_SORTED;
      if (roll >= 92) begin
         // noise: every field drawn without regard to the list
         rq.kind = TYPE_W'($urandom);
         rq.position = POS_W'($urandom);
         rq.name_key = {$urandom, $urandom};
         rq.age = AGE_W'($urandom);
      end else if (rq.kind == OP_INSERT) begin
         roll = $urandom_range(0, 9);
         rq.position = POS_W'((roll == 0) ? int'($urandom_range(0, 255)) :
                       (roll == 1) ? list_count + 1 : int'($urandom_range(0, list_count)));
      end else if (rq.kind == OP_DELETE) begin
         if (list_count > 0 && $urandom_range(0, 99) < 85)
            rq.position = POS_W'($urandom_range(0, list_count - 1));
         else
            rq.position = POS_W'(($urandom_range(0, 1) == 0) ? list_count :
                                 int'($urandom_range(0, 255)));
      end else if (rq.kind == OP_LOCATE && list_count > 0 && $urandom_range(0, 2) != 0) begin
         idx = $urandom_range(0, list_count - 1);
         rq.name_key = list_names[idx];
         rq.age = list_ages[idx];
         if ($urandom_range(0, 3) == 0)
            rq.age = rq.age + 8'd1;
      end
      return rq;
   endfunction

   // waits until every queued transaction is accepted and predicted
   task automatic wait_caught_up();
      do @(negedge clock); while (pending_requests.size() != 0 || req_valid);
   endtask

   task automatic send_directed(logic [TYPE_W-1:0] kind, logic [POS_W-1:0] position,
         logic [NAME_W-1:0] name_key, logic [AGE_W-1:0] age);
      wait_caught_up();
      pending_requests.push_back(make_request(kind, position, name_key, age));
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_replies.push_back(apply_record_request(in_flight));
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               if (idling_enabled && $urandom_range(0, 7) == 0) begin
                  send_gap <= $urandom_range(0, 3);
                  req_valid <= 1'b0;
               end else begin
                  in_flight = pending_requests.pop_front();
                  req_type <= in_flight.kind;
                  req_position <= in_flight.position;
                  req_name_key <= in_flight.name_key;
                  req_age <= in_flight.age;
                  req_valid <= 1'b1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and stall generator
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               $display("%0t: response with none expected, status %0d found %0d count %0d",
                        $time, rsp_status, rsp_found_index, rsp_entry_count);
               failures++;
            end else begin
               next_reply = expected_replies.pop_front();
               if (rsp_status !== next_reply.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, next_reply.status, rsp_status);
                  failures++;
               end
               if (rsp_found_index !== next_reply.found_index) begin
                  $display("%0t: found_index mismatch, expected %0d, actual %0d",
                           $time, $signed(next_reply.found_index), rsp_found_index);
                  failures++;
               end
               if (rsp_entry_count !== next_reply.entry_count) begin
                  $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                           $time, next_reply.entry_count, rsp_entry_count);
                  failures++;
               end
            end
         end
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (idling_enabled && $urandom_range(0, 7) == 0) begin
            hold_left <= $urandom_range(0, 3);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      bit growing;
      int n;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty list, bad positions, ends of the list and equal-name ordering
      send_directed(OP_DELETE, 8'd0, '0, 8'd0);
      send_directed(OP_LOCATE, 8'd0, '0, 8'd0);
      send_directed(OP_INSERT, 8'd1, 64'h1, 8'd1);
      send_directed(OP_INSERT, 8'd0, '1, 8'd255);
      send_directed(OP_INSERT, 8'd0, '0, 8'd0);
      send_directed(OP_INSERT, 8'd2, 64'h0123_4567_89ab_cdef, 8'h5a);
      send_directed(OP_INSERT, 8'd4, 64'h2, 8'd2);
      send_directed(OP_SORTED, 8'd0, 64'h8000_0000_0000_0000, 8'd1);
      send_directed(OP_SORTED, 8'd0, 64'h8000_0000_0000_0000, 8'd2);
      send_directed(OP_SORTED, 8'd0, '0, 8'd3);
      send_directed(OP_LOCATE, 8'd0, '1, 8'd255);
      send_directed(OP_LOCATE, 8'd0, '1, 8'd254);
      send_directed(OP_LOCATE, 8'd0, 64'h8000_0000_0000_0000, 8'd2);
      send_directed(OP_INSERT, 8'd255, 64'h3, 8'd3);
      send_directed(OP_DELETE, 8'd255, '0, 8'd0);
      send_directed(OP_DELETE, 8'd6, '0, 8'd0);
      send_directed(OP_DELETE, 8'd5, '0, 8'd0);
      send_directed(OP_DELETE, 8'd0, '0, 8'd0);
      send_directed(OP_LOCATE, 8'd0, '0, 8'd3);
      send_directed(OP_SORTED, 8'd0, '1, 8'd0);
      send_directed(OP_INSERT, 8'd5, 64'h5555_aaaa_5555_aaaa, 8'haa);
      send_directed(OP_DELETE, 8'd2, '0, 8'd0);
      send_directed(OP_INSERT, 8'd0, '1, 8'd255);
      send_directed(OP_LOCATE, 8'd0, '1, 8'd255);

      // random part: alternate filling toward full and draining toward empty
      growing = 1'b1;
      for (n = 0; n < RANDOM_COUNT; n++) begin
         wait_caught_up();
         if (n >= RANDOM_COUNT - CALM_TAIL)
            idling_enabled = 1'b0;
         else if (n % 50 == 0)
            idling_enabled = ($urandom_range(0, 3) != 0);
         if (growing && list_count == CAPACITY && $urandom_range(0, 3) == 0)
            growing = 1'b0;
         else if (!growing && list_count == 0 && $urandom_range(0, 1) == 0)
            growing = 1'b1;
         else if ($urandom_range(0, 39) == 0)
            growing = !growing;
         pending_requests.push_back(make_random_request(growing));
      end

      wait_caught_up();
      while (expected_replies.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
      if (failures == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== files.f =====
sv/olre_pkg.sv
sv/olre_ram.sv
sv/olre_seq.sv
sv/ordered_record_list_engine.sv
test/ordered_record_list_engine_tb.sv
